// ===== sv/adtdm_pkg.sv =====
// Package for the ADC TDM data port deframer.
// Holds configuration register indexes and fixed field widths; no dependencies.
package adtdm_pkg;

  // Fixed widths of the payload and register fields
  localparam int unsigned RawW       = 8;
  localparam int unsigned SampleW    = 24;
  localparam int unsigned PartialW   = 16;
  localparam int unsigned ChanW      = 3;
  localparam int unsigned FrameCfgW  = 14;
  localparam int unsigned ChanBytesW = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 14;

  // Bytes per sample, counted 0..2
  localparam logic [1:0] LastSampleByte = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_BYTES   = 2'd0,
    CFG_CHANNEL_BYTES = 2'd1,
    CFG_FIRST_CHANNEL = 2'd2,
    CFG_LAST_CHANNEL  = 2'd3
  } cfg_idx_e;

endpackage

// ===== sv/adc_tdm_data_port_deframer_top.sv =====
// ADC TDM data port deframer: bit realignment, frame padding removal, 24-bit sample assembly.
// Finished samples go to the output register, or to the skid register on an output stall.
// Throughput: one input request per cycle; the input stalls only while the skid register
// holds a sample that the output side has not yet taken.
// Reset (asynchronous, active low): registers go to their documented defaults, the
// alignment and frame counters clear, and both output registers empty.
// Depends on adtdm_pkg.
module adc_tdm_data_port_deframer_top
  import adtdm_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  // raw byte input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [RawW-1:0]            rx_byte_i,
  input  logic                       capture_start_i,
  // sample output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SampleW-1:0]  sample_value_o,
  output logic [ChanW-1:0]           channel_id_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned CmpW = (PosW + 1 > FrameCfgW) ? PosW + 1 : FrameCfgW;
  localparam logic [CmpW-1:0] MaxFrame = CmpW'(MAX_FRAME_BYTES);

  // configuration registers
  logic [FrameCfgW-1:0]  frame_bytes_q;
  logic [ChanBytesW-1:0] channel_bytes_q;
  logic [ChanW-1:0]      first_channel_q;
  logic [ChanW-1:0]      last_channel_q;

  // deframer state
  logic [RawW-1:0]     held_q, held_d;
  logic                held_valid_q, held_valid_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [PartialW-1:0] partial_q, partial_d;
  logic [ChanW-1:0]    chan_q, chan_d;

  // output and skid registers
  logic               out_valid_q;
  logic [SampleW-1:0] out_value_q;
  logic [ChanW-1:0]   out_chan_q;
  logic               skid_valid_q;
  logic [SampleW-1:0] skid_value_q;
  logic [ChanW-1:0]   skid_chan_q;

  logic               in_acc;
  logic               out_take;
  logic               res_valid;
  logic [SampleW-1:0] res_value;
  logic [ChanW-1:0]   res_chan;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_value_q;
  assign channel_id_o   = out_chan_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q   <= FrameCfgW'(64);
      channel_bytes_q <= ChanBytesW'(24);
      first_channel_q <= '0;
      last_channel_q  <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_BYTES:   frame_bytes_q   <= cfg_data_i;
        CFG_CHANNEL_BYTES: channel_bytes_q <= cfg_data_i[ChanBytesW-1:0];
        CFG_FIRST_CHANNEL: first_channel_q <= cfg_data_i[ChanW-1:0];
        CFG_LAST_CHANNEL:  last_channel_q  <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // realignment, frame tracking and sample assembly for one request
  always_comb begin
    logic [RawW-1:0]   aligned;
    logic [CmpW-1:0]   flen;
    logic [CmpW-1:0]   next_pos;
    logic [1:0]        cnt;
    logic [PartialW-1:0] part;
    logic [ChanW-1:0]  chan;

    held_d       = held_q;
    held_valid_d = held_valid_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    partial_d    = partial_q;
    chan_d       = chan_q;
    res_valid    = 1'b0;
    res_value    = '0;
    res_chan     = '0;

    aligned  = {held_q[RawW-2:0], rx_byte_i[RawW-1]};
    flen     = (CmpW'(frame_bytes_q) > MaxFrame) ? MaxFrame : CmpW'(frame_bytes_q);
    next_pos = CmpW'(pos_q) + CmpW'(1);
    cnt      = cnt_q;
    part     = partial_q;
    chan     = chan_q;

    if (pos_q == '0) begin
      cnt  = '0;
      part = '0;
      chan = first_channel_q;
    end

    if (in_acc) begin
      held_d       = rx_byte_i;
      held_valid_d = 1'b1;
      if (capture_start_i) begin
        // restart alignment and frame counters
        pos_d     = '0;
        cnt_d     = '0;
        partial_d = '0;
        chan_d    = first_channel_q;
      end else if (held_valid_q) begin
        cnt_d     = cnt;
        partial_d = part;
        chan_d    = chan;
        if (CmpW'(pos_q) < CmpW'(channel_bytes_q)) begin
          if (cnt != LastSampleByte) begin
            partial_d = {part[RawW-1:0], aligned};
            cnt_d     = cnt + 2'd1;
          end else begin
            res_valid = 1'b1;
            res_value = {part, aligned};
            res_chan  = chan;
            cnt_d     = '0;
            partial_d = '0;
            chan_d    = (chan == last_channel_q) ? first_channel_q : chan + ChanW'(1);
          end
        end
        pos_d = (next_pos >= flen) ? '0 : next_pos[PosW-1:0];
      end
    end
  end

  // deframer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      pos_q        <= '0;
      cnt_q        <= '0;
      partial_q    <= '0;
      chan_q       <= '0;
    end else begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      pos_q        <= pos_d;
      cnt_q        <= cnt_d;
      partial_q    <= partial_d;
      chan_q       <= chan_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_take) begin
      skid_valid_q <= res_valid;
    end else begin
      out_valid_q <= res_valid;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_value_q <= skid_value_q;
        out_chan_q  <= skid_chan_q;
      end
    end else if (out_valid_q && !out_take) begin
      if (res_valid) begin
        skid_value_q <= res_value;
        skid_chan_q  <= res_chan;
      end
    end else if (res_valid) begin
      out_value_q <= res_value;
      out_chan_q  <= res_chan;
    end
  end

endmodule
